/* rtl/oximeter_live_packet_parser_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the oximeter live packet parser
// Short forms for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef OXIMETER_LIVE_PACKET_PARSER_MACROS_SVH
`define OXIMETER_LIVE_PACKET_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OLPP_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("olpp: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define OLPP_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("olpp: next-cycle check failed");

`endif

/* rtl/olpp_pkg.sv */
// ---------------------------------------------------------------------------
// olpp_pkg
// Constants and helpers shared by the live packet parser.
// ---------------------------------------------------------------------------
package olpp_pkg;

  // Default number of body bytes in one live-data packet.
  localparam int BODY_BYTES_DEF = 7;

  // Type byte that opens a live-data packet.
  localparam logic [7:0] LIVE_TYPE = 8'h01;

  // Width of the packed result word (28 field bits padded to whole bytes).
  localparam int RESULT_W = 32;

  // Restore a body byte: the seven low bits as received, bit 7 from the
  // high-bits byte.
  function automatic logic [7:0] restore_byte(input logic [6:0] raw, input logic top);
    restore_byte = {top, raw};
  endfunction

endpackage

/* rtl/oximeter_live_packet_parser.sv */
// ---------------------------------------------------------------------------
// oximeter_live_packet_parser
// Deframes live-data packets from a pulse oximeter byte stream.
// ---------------------------------------------------------------------------
// One received byte is taken per transaction on the slave side, and the
// block accepts a byte in every cycle unless stalled as described below.
// Each byte first lands in an input register; the parser then updates its
// phase, the high-bits byte and the body store in a single pass, and a
// completed packet is written into the result register as the last body
// byte leaves the input register, and the reading is then offered on the
// master side from the result register. A packet is a type byte of 0x01, a
// high-bits byte with bit 7 set, and BODY_BYTES body bytes; other type
// bytes are dropped, and a byte with bit 7 clear in the high-bits slot is
// taken again as a type byte. The only stall arises when the byte that
// completes a packet meets a result still waiting in the result register;
// every other byte passes regardless of the master side.
// ---------------------------------------------------------------------------
`include "oximeter_live_packet_parser_macros.svh"

module oximeter_live_packet_parser
  import olpp_pkg::*;
#(
  parameter int BODY_BYTES = BODY_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] rx_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [RESULT_W-1:0] m_tdata    // [3:0] strength, [4] beep,
                                         // [11:5] wave sample, [19:12] rate,
                                         // [27:20] oxygen_saturation, [31:28] zero
);

  localparam int IDX_W = $clog2(BODY_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;

  // Parser state.
  phase_t     phase;
  logic [7:0] top_bits;
  logic [2:0] bytes_left;
  logic [6:0] body_store [BODY_BYTES];

  // Next values and decode of the byte in the input register.
  phase_t     phase_next;
  logic [7:0] top_bits_next;
  logic [2:0] bytes_left_next;
  logic [2:0] idx_full;
  logic [IDX_W-1:0] idx;
  logic       body_wr;
  logic       emit;
  logic       advance;
  logic [6:0] body_view [BODY_BYTES];
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [RESULT_W-1:0] result_next;

  assign idx_full = 3'(BODY_BYTES) - bytes_left;
  assign idx      = idx_full[IDX_W-1:0];

  always_comb begin
    phase_next      = phase;
    top_bits_next   = top_bits;
    bytes_left_next = bytes_left;
    body_wr         = 1'b0;
    emit            = 1'b0;
    unique case (phase)
      PH_HIGH: begin
        if (!in_byte[7]) begin
          // A type byte in the high-bits slot restarts the search.
          if (in_byte == LIVE_TYPE) begin
            bytes_left_next = 3'(BODY_BYTES);
            phase_next      = PH_HIGH;
          end else begin
            phase_next = PH_IDLE;
          end
        end else begin
          top_bits_next = in_byte;
          phase_next    = PH_BODY;
        end
      end
      PH_BODY: begin
        body_wr         = (idx_full < 3'(BODY_BYTES));
        bytes_left_next = bytes_left - 3'd1;
        if (bytes_left == 3'd1) begin
          emit       = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        // Idle, and the unused phase code treated as idle.
        phase_next = PH_IDLE;
        if (!in_byte[7]) begin
          if (in_byte == LIVE_TYPE) begin
            bytes_left_next = 3'(BODY_BYTES);
            phase_next      = PH_HIGH;
          end
        end
      end
    endcase
  end

  // The byte being stored this cycle is visible to the result at once, as
  // the last body byte may itself be one of the reported bytes.
  always_comb begin
    for (int i = 0; i < BODY_BYTES; i++) begin
      body_view[i] = (body_wr && idx == IDX_W'(i)) ? in_byte[6:0] : body_store[i];
    end
  end

  assign byte0 = restore_byte(body_view[0], top_bits[0]);
  assign byte1 = restore_byte(body_view[1], top_bits[1]);
  assign byte3 = restore_byte(body_view[3], top_bits[3]);
  assign byte4 = restore_byte(body_view[4], top_bits[4]);

  assign result_next = {4'd0, byte4, byte3, byte1[6:0], byte0[6], byte0[3:0]};

  // The stage moves on unless a completed packet would overwrite a result
  // that the master side has not yet taken.
  assign advance  = in_valid && (!emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      phase      <= PH_IDLE;
      top_bits   <= 8'd0;
      bytes_left <= 3'd0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_byte  <= s_tdata;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        phase      <= phase_next;
        top_bits   <= top_bits_next;
        bytes_left <= bytes_left_next;
        if (body_wr) begin
          body_store[idx] <= in_byte[6:0];
        end
      end

      if (advance && emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= result_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // A result is only ever produced by the last body byte of a packet.
  `OLPP_ASSERT_SAME(a_emit_on_last, clk, rst, emit, phase == PH_BODY && bytes_left == 3'd1)
  // While collecting the body there is always at least one byte to go.
  `OLPP_ASSERT_SAME(a_body_count, clk, rst, phase == PH_BODY, bytes_left != 3'd0)
  // A byte held back in the input register keeps its value.
  `OLPP_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !advance,
                    in_valid && $stable(in_byte))
  // Coming out of reset the parser is idle with no result pending.
  `OLPP_ASSERT_SAME(a_reset_idle, clk, rst, $past(rst), phase == PH_IDLE && !m_tvalid)

endmodule
